// ===== src/pfvd_pkg.sv =====
// shared constants for the particle force velocity increment pipeline
`default_nettype none
package pfvd_pkg;

  localparam int PFVD_FRAC_BITS = 16;

  localparam int POS_W  = 32;  // signed position and force words
  localparam int MASS_W = 31;
  localparam int DT_W   = 31;
  localparam int Q_W    = 32;  // quotient bits resolved by the divider

  // radial numerator |d| * |fx| * dt and radial denominator mass * dist2
  localparam int RNUM_W = MASS_W + POS_W + DT_W;
  localparam int RDEN_W = MASS_W + 2 * MASS_W;
  // directional numerator |f| * dt and denominator mass * dist
  localparam int FDT_W  = POS_W + DT_W;
  localparam int DDEN_W = 2 * MASS_W;

  localparam int SQ_STEPS = 32;  // one result bit of the square root per stage
  localparam int DV_STEPS = Q_W; // one quotient bit per stage

  // accept edge to the edge at which the strobe is seen
  localparam int PFVD_LATENCY = 7 + SQ_STEPS + 2 + DV_STEPS;

endpackage
`default_nettype wire

// ===== src/particle_force_velocity_delta.sv =====
// top level: velocity increment of one particle from one force source
`default_nettype none
// Fully pipelined: a particle-source word is taken at every clock edge with start high and
// busy low (busy is high only during reset), and its result appears on the result ports,
// marked by done for one cycle. The pipeline depth is set by the 32-stage square-root
// pipeline and the 32-stage restoring divider, one result bit per stage, plus nine stages
// of offset, multiply, load and select logic. The result cannot be held off, so nothing in
// the pipeline ever stalls. The user must write time_step with cfg_we only while no word
// is in flight; the block itself does not enforce this.
module particle_force_velocity_delta #(
  parameter int FRAC_BITS = pfvd_pkg::PFVD_FRAC_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            cfg_we,
  input  wire logic [pfvd_pkg::DT_W-1:0]       cfg_wdata,
  input  wire logic                            mode,
  input  wire logic signed [pfvd_pkg::POS_W-1:0] particle_x,
  input  wire logic signed [pfvd_pkg::POS_W-1:0] particle_y,
  input  wire logic signed [pfvd_pkg::POS_W-1:0] particle_z,
  input  wire logic [pfvd_pkg::MASS_W-1:0]     particle_mass,
  input  wire logic signed [pfvd_pkg::POS_W-1:0] source_x,
  input  wire logic signed [pfvd_pkg::POS_W-1:0] source_y,
  input  wire logic signed [pfvd_pkg::POS_W-1:0] source_z,
  input  wire logic [pfvd_pkg::MASS_W-1:0]     reach,
  input  wire logic signed [pfvd_pkg::POS_W-1:0] force_x,
  input  wire logic signed [pfvd_pkg::POS_W-1:0] force_y,
  input  wire logic signed [pfvd_pkg::POS_W-1:0] force_z,
  output logic                                 done,
  output logic signed [pfvd_pkg::POS_W-1:0]    delta_vx,
  output logic signed [pfvd_pkg::POS_W-1:0]    delta_vy,
  output logic signed [pfvd_pkg::POS_W-1:0]    delta_vz,
  output logic                                 in_reach,
  output logic                                 coincident
);
  import pfvd_pkg::*;

  localparam int NUM_W  = RNUM_W + FRAC_BITS;
  localparam int WIDE_W = (NUM_W > RDEN_W + Q_W) ? NUM_W : RDEN_W + Q_W;

  typedef struct packed {
    logic                          mode;
    logic [MASS_W-1:0]             mass;
    logic                          hit;
    logic                          coin;
    logic [2:0]                    neg;
    logic [2:0][RNUM_W-1:0]        rnum;
    logic [RDEN_W-1:0]             rden;
    logic [2:0][FDT_W-1:0]         fdt;
  } carry_t;

  logic [DT_W-1:0] time_step;

  // stage 1: offsets
  logic                     v1, s1_mode;
  logic [MASS_W-1:0]        s1_mass, s1_reach;
  logic signed [POS_W:0]    s1_d [3];
  logic signed [POS_W-1:0]  s1_f [3];
  // stage 2: magnitudes and per-axis reach test
  logic                     v2, s2_mode, s2_far;
  logic [MASS_W-1:0]        s2_mass, s2_reach;
  logic [MASS_W-1:0]        s2_dm [3];
  logic [POS_W-1:0]         s2_fm [3];
  logic [2:0]               s2_neg;
  // stage 3: products
  logic                     v3, s3_mode, s3_far;
  logic [MASS_W-1:0]        s3_mass;
  logic [2*MASS_W-1:0]      s3_sq [3];
  logic [2*MASS_W-1:0]      s3_r2;
  logic [FDT_W-1:0]         s3_fdt [3];
  logic [MASS_W+POS_W-1:0]  s3_dfx [3];
  logic [2:0]               s3_neg;
  // stage 4: squared distance, radial numerator partial products
  logic                     v4, s4_mode, s4_far;
  logic [MASS_W-1:0]        s4_mass;
  logic [63:0]              s4_dist2;
  logic [2*MASS_W-1:0]      s4_r2;
  logic [FDT_W-1:0]         s4_fdt [3];
  logic [32+DT_W-1:0]       s4_lo [3];
  logic [MASS_W+DT_W-1:0]   s4_hi [3];
  logic [2:0]               s4_neg;
  // stage 5: reach decision, radial denominator partial products
  logic                     v5, s5_mode, s5_hit, s5_coin;
  logic [MASS_W-1:0]        s5_mass;
  logic [2*MASS_W-1:0]      s5_dist2;
  logic [RNUM_W-1:0]        s5_rnum [3];
  logic [FDT_W-1:0]         s5_fdt [3];
  logic [2*MASS_W-1:0]      s5_pl, s5_ph;
  logic [2:0]               s5_neg;
  carry_t                   c5;

  // square root pipeline
  logic                     sq_ok [SQ_STEPS+1];
  logic [63:0]              sq_v  [SQ_STEPS+1];
  logic [63:0]              sq_r  [SQ_STEPS+1];
  carry_t                   sq_c  [SQ_STEPS+1];
  logic [63:0]              sq_vn [SQ_STEPS];
  logic [63:0]              sq_rn [SQ_STEPS];

  // directional denominator
  logic                     d1_ok;
  logic [DDEN_W-1:0]        d1_dden;
  carry_t                   d1_c;
  logic [NUM_W-1:0]         d1_num [3];
  logic [RDEN_W-1:0]        d1_den;

  // divider pipeline
  logic                     dv_ok   [DV_STEPS+1];
  logic [NUM_W-1:0]         dv_rem  [DV_STEPS+1][3];
  logic [Q_W-1:0]           dv_q    [DV_STEPS+1][3];
  logic [RDEN_W-1:0]        dv_den  [DV_STEPS+1];
  logic [2:0]               dv_ovf  [DV_STEPS+1];
  logic [2:0]               dv_neg  [DV_STEPS+1];
  logic                     dv_hit  [DV_STEPS+1];
  logic                     dv_coin [DV_STEPS+1];
  logic [NUM_W-1:0]         dv_remn [DV_STEPS][3];
  logic [Q_W-1:0]           dv_qn   [DV_STEPS][3];

  logic signed [POS_W-1:0]  res [3];

  assign busy = rst;

  // stage 2 combinational magnitudes
  logic [POS_W:0]           dmag [3];
  logic [POS_W-1:0]         fmag [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dmag[i] = s1_d[i][POS_W] ? (POS_W+1)'(-s1_d[i]) : (POS_W+1)'(s1_d[i]);
      fmag[i] = s1_f[i][POS_W-1] ? POS_W'(-s1_f[i]) : POS_W'(s1_f[i]);
    end
  end

  always_comb begin
    c5.mode = s5_mode;
    c5.mass = s5_mass;
    c5.hit  = s5_hit;
    c5.coin = s5_coin;
    c5.neg  = s5_neg;
    for (int i = 0; i < 3; i++) begin
      c5.rnum[i] = s5_rnum[i];
      c5.fdt[i]  = s5_fdt[i];
    end
    c5.rden = {s5_ph, {MASS_W{1'b0}}} + RDEN_W'(s5_pl);
  end

  // one bit of the integer square root per stage
  always_comb begin
    for (int k = 0; k < SQ_STEPS; k++) begin
      logic [63:0] bitv;
      logic [63:0] trial;
      bitv  = 64'd1 << (62 - 2 * k);
      trial = sq_r[k] + bitv;
      if (sq_v[k] >= trial) begin
        sq_vn[k] = sq_v[k] - trial;
        sq_rn[k] = (sq_r[k] >> 1) + bitv;
      end else begin
        sq_vn[k] = sq_v[k];
        sq_rn[k] = sq_r[k] >> 1;
      end
    end
  end

  // numerator and denominator chosen by mode
  always_comb begin
    d1_den = d1_c.mode ? d1_c.rden : RDEN_W'(d1_dden);
    for (int i = 0; i < 3; i++) begin
      d1_num[i] = d1_c.mode ? (NUM_W'(d1_c.rnum[i]) << FRAC_BITS)
                            : (NUM_W'(d1_c.fdt[i]) << FRAC_BITS);
    end
  end

  // one quotient bit per stage, msb first
  always_comb begin
    for (int j = 0; j < DV_STEPS; j++) begin
      for (int i = 0; i < 3; i++) begin
        logic [WIDE_W-1:0] shifted;
        shifted = WIDE_W'(dv_den[j]) << (Q_W - 1 - j);
        if (WIDE_W'(dv_rem[j][i]) >= shifted) begin
          dv_remn[j][i] = NUM_W'(WIDE_W'(dv_rem[j][i]) - shifted);
          dv_qn[j][i]   = dv_q[j][i] | (Q_W'(1) << (Q_W - 1 - j));
        end else begin
          dv_remn[j][i] = dv_rem[j][i];
          dv_qn[j][i]   = dv_q[j][i];
        end
      end
    end
  end

  // saturation and sign
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [Q_W-1:0] limit;
      logic [Q_W-1:0] mag;
      limit = dv_neg[DV_STEPS][i] ? 32'h8000_0000 : 32'h7fff_ffff;
      mag   = (dv_ovf[DV_STEPS][i] || dv_q[DV_STEPS][i] > limit) ? limit
                                                                   : dv_q[DV_STEPS][i];
      if (!dv_hit[DV_STEPS] || dv_coin[DV_STEPS]) begin
        res[i] = '0;
      end else begin
        res[i] = dv_neg[DV_STEPS][i] ? POS_W'(-mag) : POS_W'(mag);
      end
    end
  end

  // control: valid bits and the register
  always_ff @(posedge clk) begin
    if (cfg_we) begin
      time_step <= cfg_wdata;
    end else if (rst) begin
      time_step <= '0;
    end
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      for (int k = 0; k <= SQ_STEPS; k++) sq_ok[k] <= 1'b0;
      d1_ok <= 1'b0;
      for (int j = 0; j <= DV_STEPS; j++) dv_ok[j] <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      sq_ok[0] <= v5;
      for (int k = 0; k < SQ_STEPS; k++) sq_ok[k+1] <= sq_ok[k];
      d1_ok <= sq_ok[SQ_STEPS];
      dv_ok[0] <= d1_ok;
      for (int j = 0; j < DV_STEPS; j++) dv_ok[j+1] <= dv_ok[j];
      done <= dv_ok[DV_STEPS];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    s1_mode  <= mode;
    s1_mass  <= (particle_mass == '0) ? MASS_W'(1) : particle_mass;
    s1_reach <= reach;
    s1_d[0]  <= $signed({particle_x[POS_W-1], particle_x}) - $signed({source_x[POS_W-1], source_x});
    s1_d[1]  <= $signed({particle_y[POS_W-1], particle_y}) - $signed({source_y[POS_W-1], source_y});
    s1_d[2]  <= $signed({particle_z[POS_W-1], particle_z}) - $signed({source_z[POS_W-1], source_z});
    s1_f[0]  <= force_x;
    s1_f[1]  <= force_y;
    s1_f[2]  <= force_z;

    s2_mode  <= s1_mode;
    s2_mass  <= s1_mass;
    s2_reach <= s1_reach;
    s2_far   <= (dmag[0] > (POS_W+1)'(s1_reach)) || (dmag[1] > (POS_W+1)'(s1_reach))
             || (dmag[2] > (POS_W+1)'(s1_reach));
    for (int i = 0; i < 3; i++) begin
      // far axes are dropped, so the low bits are all that matter
      s2_dm[i]  <= dmag[i][MASS_W-1:0];
      s2_fm[i]  <= fmag[i];
      s2_neg[i] <= s1_mode ? (s1_d[i][POS_W] ^ s1_f[0][POS_W-1]) : s1_f[i][POS_W-1];
    end

    s3_mode <= s2_mode;
    s3_mass <= s2_mass;
    s3_far  <= s2_far;
    s3_neg  <= s2_neg;
    s3_r2   <= {{MASS_W{1'b0}}, s2_reach} * {{MASS_W{1'b0}}, s2_reach};
    for (int i = 0; i < 3; i++) begin
      s3_sq[i]  <= {{MASS_W{1'b0}}, s2_dm[i]} * {{MASS_W{1'b0}}, s2_dm[i]};
      s3_fdt[i] <= FDT_W'(s2_fm[i]) * FDT_W'(time_step);
      s3_dfx[i] <= (MASS_W+POS_W)'(s2_dm[i]) * (MASS_W+POS_W)'(s2_fm[0]);
    end

    s4_mode  <= s3_mode;
    s4_mass  <= s3_mass;
    s4_far   <= s3_far;
    s4_neg   <= s3_neg;
    s4_r2    <= s3_r2;
    s4_dist2 <= 64'(s3_sq[0]) + 64'(s3_sq[1]) + 64'(s3_sq[2]);
    for (int i = 0; i < 3; i++) begin
      s4_fdt[i] <= s3_fdt[i];
      s4_lo[i]  <= (32+DT_W)'(s3_dfx[i][31:0]) * (32+DT_W)'(time_step);
      s4_hi[i]  <= (MASS_W+DT_W)'(s3_dfx[i][MASS_W+POS_W-1:32]) * (MASS_W+DT_W)'(time_step);
    end

    s5_mode  <= s4_mode;
    s5_mass  <= s4_mass;
    s5_neg   <= s4_neg;
    s5_hit   <= !s4_far && (s4_dist2 <= 64'(s4_r2));
    s5_coin  <= (s4_dist2 == '0);
    s5_dist2 <= s4_dist2[2*MASS_W-1:0];
    s5_pl    <= (2*MASS_W)'(s4_mass) * (2*MASS_W)'(s4_dist2[MASS_W-1:0]);
    s5_ph    <= (2*MASS_W)'(s4_mass) * (2*MASS_W)'(s4_dist2[2*MASS_W-1:MASS_W]);
    for (int i = 0; i < 3; i++) begin
      s5_fdt[i]  <= s4_fdt[i];
      s5_rnum[i] <= {s4_hi[i], 32'd0} + RNUM_W'(s4_lo[i]);
    end

    sq_v[0] <= 64'(s5_dist2);
    sq_r[0] <= '0;
    sq_c[0] <= c5;
    for (int k = 0; k < SQ_STEPS; k++) begin
      sq_v[k+1] <= sq_vn[k];
      sq_r[k+1] <= sq_rn[k];
      sq_c[k+1] <= sq_c[k];
    end

    d1_c    <= sq_c[SQ_STEPS];
    d1_dden <= DDEN_W'(sq_c[SQ_STEPS].mass) * DDEN_W'(sq_r[SQ_STEPS][MASS_W-1:0]);

    dv_den[0]  <= d1_den;
    dv_neg[0]  <= d1_c.neg;
    dv_hit[0]  <= d1_c.hit;
    dv_coin[0] <= d1_c.coin;
    for (int i = 0; i < 3; i++) begin
      dv_rem[0][i] <= d1_num[i];
      dv_q[0][i]   <= '0;
      // quotient at or above 2^32 saturates regardless of the low bits
      dv_ovf[0][i] <= WIDE_W'(d1_num[i]) >= (WIDE_W'(d1_den) << Q_W);
    end
    for (int j = 0; j < DV_STEPS; j++) begin
      dv_den[j+1]  <= dv_den[j];
      dv_ovf[j+1]  <= dv_ovf[j];
      dv_neg[j+1]  <= dv_neg[j];
      dv_hit[j+1]  <= dv_hit[j];
      dv_coin[j+1] <= dv_coin[j];
      for (int i = 0; i < 3; i++) begin
        dv_rem[j+1][i] <= dv_remn[j][i];
        dv_q[j+1][i]   <= dv_qn[j][i];
      end
    end

    delta_vx   <= res[0];
    delta_vy   <= res[1];
    delta_vz   <= res[2];
    in_reach   <= dv_hit[DV_STEPS];
    coincident <= dv_hit[DV_STEPS] && dv_coin[DV_STEPS];
  end

endmodule
`default_nettype wire

// ===== src/pfvd_checker.sv =====
// port-level checks for the velocity increment pipeline, bound to the top level
`default_nettype none
module pfvd_checker (
  input wire logic                                  clk,
  input wire logic                                  rst,
  input wire logic                                  start,
  input wire logic                                  busy,
  input wire logic                                  done,
  input wire logic signed [pfvd_pkg::POS_W-1:0]     delta_vx,
  input wire logic signed [pfvd_pkg::POS_W-1:0]     delta_vy,
  input wire logic signed [pfvd_pkg::POS_W-1:0]     delta_vz,
  input wire logic                                  in_reach,
  input wire logic                                  coincident
);
  import pfvd_pkg::*;

  // every accepted word comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PFVD_LATENCY done)
    else $error("accepted word produced no result");

  // no result without an accepted word
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##PFVD_LATENCY !done)
    else $error("result without an accepted word");

  a_far_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !in_reach) |->
      (delta_vx == '0 && delta_vy == '0 && delta_vz == '0 && !coincident))
    else $error("out of reach word gave a nonzero increment");

  a_coin_zero: assert property (@(posedge clk) disable iff (rst)
    (done && coincident) |->
      (in_reach && delta_vx == '0 && delta_vy == '0 && delta_vz == '0))
    else $error("coincident word gave a nonzero increment");

endmodule

bind particle_force_velocity_delta pfvd_checker u_pfvd_checker (.*);
`default_nettype wire
